FILE: src/cdsu_pkg.sv
// ----------------------------------------------------------------------------
// cdsu_pkg
// Shared types, constants and calendar helper functions for the date stepper.
// ----------------------------------------------------------------------------
package cdsu_pkg;

    localparam int DEF_MIN_YEAR = 1900;
    localparam int DEF_MAX_YEAR = 2200;

    localparam logic [11:0] SERIAL_FIRST = 12'd1900;
    localparam logic [11:0] SERIAL_LAST  = 12'd2200;
    localparam logic [11:0] SERIAL_GAP   = 12'd2100;

    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_DEC = 4'd12;
    localparam logic [4:0] DAY_DEC_END = 5'd31;

    typedef enum logic [2:0] {
        REQ_LOAD     = 3'd0,
        REQ_DAYS     = 3'd1,
        REQ_WEEKS    = 3'd2,
        REQ_MONTHS   = 3'd3,
        REQ_QUARTERS = 3'd4,
        REQ_YEARS    = 3'd5,
        REQ_EOM      = 3'd6,
        REQ_EOY      = 3'd7
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DAYS,
        S_DIV,
        S_CLAMP,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic decode;
        logic day_step;
        logic div_step;
        logic clamp;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic go_days;
        logic go_div;
        logic days_zero;
    } t_sts;

    // Month length; zero for a month code outside 1..12.
    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                      len = leap ? 5'd29 : 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of the month in a common year.
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] s;
        case (m)
            4'd1:    s = 9'd0;
            4'd2:    s = 9'd31;
            4'd3:    s = 9'd59;
            4'd4:    s = 9'd90;
            4'd5:    s = 9'd120;
            4'd6:    s = 9'd151;
            4'd7:    s = 9'd181;
            4'd8:    s = 9'd212;
            4'd9:    s = 9'd243;
            4'd10:   s = 9'd273;
            4'd11:   s = 9'd304;
            4'd12:   s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

FILE: src/cdsu_ctrl.sv
// ----------------------------------------------------------------------------
// cdsu_ctrl
// Request sequencer: handshakes and the command stream for the datapath.
// ----------------------------------------------------------------------------
module cdsu_ctrl import cdsu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_valid) n_state = S_DECODE;
            S_DECODE: begin
                if (i_sts.go_days)     n_state = S_DAYS;
                else if (i_sts.go_div) n_state = S_DIV;
                else                   n_state = S_FINISH;
            end
            S_DAYS:   if (i_sts.days_zero) n_state = S_FINISH;
            S_DIV:    n_state = S_CLAMP;
            S_CLAMP:  n_state = S_FINISH;
            S_FINISH: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_ready     = 1'b0;
        n_out_valid = r_out_valid && !i_ready;
        case (r_state)
            S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.capture = i_valid;
            end
            S_DECODE: o_cmd.decode = 1'b1;
            S_DAYS:   o_cmd.day_step = !i_sts.days_zero;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_CLAMP:  o_cmd.clamp = 1'b1;
            S_FINISH: begin
                o_cmd.finish = out_free;
                if (out_free) n_out_valid = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_valid = r_out_valid;

endmodule

FILE: src/cdsu_dpath.sv
// ----------------------------------------------------------------------------
// cdsu_dpath
// Date registers, day stepper, divide-by-twelve unit and result registers.
// ----------------------------------------------------------------------------
module cdsu_dpath import cdsu_pkg::*; #(
    parameter int MIN_YEAR = DEF_MIN_YEAR,
    parameter int MAX_YEAR = DEF_MAX_YEAR
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic        [2:0]  i_req_type,
    input  logic signed [12:0] i_amount,
    input  logic        [11:0] i_load_year,
    input  logic        [3:0]  i_load_month,
    input  logic        [4:0]  i_load_day,
    output logic        [11:0] o_year,
    output logic        [3:0]  o_month,
    output logic        [4:0]  o_day,
    output logic               o_date_valid,
    output logic               o_leap_year,
    output logic               o_end_of_month,
    output logic               o_end_of_year,
    output logic        [16:0] o_serial_day,
    output logic               o_status
);

    localparam logic [11:0]        MIN_Y  = 12'(MIN_YEAR);
    localparam logic [11:0]        MAX_Y  = 12'(MAX_YEAR);
    localparam logic signed [18:0] TOT_LO = 19'(MIN_YEAR * 12);
    localparam logic signed [18:0] TOT_HI = 19'(MAX_YEAR * 12 + 11);
    // Rounded-up 2^16 / 3; exact for every dividend below 2^15.
    localparam logic [30:0]        RECIP_3 = 31'd21846;

    // Stored date and per-request state.
    logic [11:0] r_year, n_year;
    logic [3:0]  r_month, n_month;
    logic [4:0]  r_day, n_day;
    logic [15:0] r_days_left, n_days_left;
    logic        r_fwd, n_fwd;
    logic        r_status, n_status;

    // Captured request.
    t_req               r_req;
    logic signed [12:0] r_amt;
    logic [11:0]        r_ly;
    logic [3:0]         r_lm;
    logic [4:0]         r_ld;

    // Divider.
    logic [16:0] r_dvd, n_dvd;
    logic [11:0] r_quo, n_quo;
    logic [3:0]  r_rem, n_rem;

    function automatic logic date_ok(input logic [11:0] y, input logic [3:0] m,
                                     input logic [4:0] d);
        logic [4:0] len;
        len = month_len(y[1:0] == 2'b00, m);
        return (y >= MIN_Y) && (y <= MAX_Y) && (len != 5'd0) && (d >= 5'd1) && (d <= len);
    endfunction

    logic               cur_ok, load_ok;
    logic signed [16:0] day_n;
    logic [16:0]        day_abs;
    logic signed [18:0] mon_n, total;
    logic               tot_ok, is_day, is_mon;
    logic [4:0]         cur_len, prev_len, tgt_len;
    logic [30:0]        quo_prod;
    logic [14:0]        quo_full;
    logic [3:0]         div_rem;

    always_comb begin
        cur_ok  = date_ok(r_year, r_month, r_day);
        load_ok = date_ok(r_ly, r_lm, r_ld);
        is_day  = (r_req == REQ_DAYS) || (r_req == REQ_WEEKS);
        is_mon  = (r_req == REQ_MONTHS) || (r_req == REQ_QUARTERS) || (r_req == REQ_YEARS);
        if (r_req == REQ_WEEKS) day_n = 17'(r_amt) * 17'sd7;
        else                    day_n = 17'(r_amt);
        day_abs = day_n[16] ? 17'(-day_n) : 17'(day_n);
        case (r_req)
            REQ_QUARTERS: mon_n = 19'(r_amt) * 19'sd3;
            REQ_YEARS:    mon_n = 19'(r_amt) * 19'sd12;
            default:      mon_n = 19'(r_amt);
        endcase
        total = $signed({3'b000, r_year, 4'b0000} - {5'b00000, r_year, 2'b00})
                + $signed({15'd0, r_month}) - 19'sd1 + mon_n;
        tot_ok   = (total >= TOT_LO) && (total <= TOT_HI);
        cur_len  = month_len(r_year[1:0] == 2'b00, r_month);
        prev_len = month_len(r_year[1:0] == 2'b00, r_month - 4'd1);
        tgt_len  = month_len(r_quo[1:0] == 2'b00, r_rem + 4'd1);
        // Month count divided by twelve: drop two bits, then divide by three
        // with a reciprocal multiply. The remainder needs only the low bits.
        quo_prod = {16'd0, r_dvd[16:2]} * RECIP_3;
        quo_full = quo_prod[30:16];
        div_rem  = r_dvd[3:0] - {quo_full[0], 3'b000} - {quo_full[1:0], 2'b00};
    end

    assign o_sts.go_days   = is_day && cur_ok && (day_n > 17'sd0 || day_n < 17'sd0);
    assign o_sts.go_div    = is_mon && cur_ok && tot_ok;
    assign o_sts.days_zero = (r_days_left == 16'd0);

    always_comb begin
        n_year      = r_year;
        n_month     = r_month;
        n_day       = r_day;
        n_days_left = r_days_left;
        n_fwd       = r_fwd;
        n_status    = r_status;
        n_dvd       = r_dvd;
        n_quo       = r_quo;
        n_rem       = r_rem;
        if (i_cmd.decode) begin
            n_status = 1'b0;
            if (r_req == REQ_LOAD) begin
                if (load_ok) begin
                    n_year  = r_ly;
                    n_month = r_lm;
                    n_day   = r_ld;
                end else begin
                    n_status = 1'b1;
                end
            end else if (!cur_ok) begin
                n_status = 1'b1;
            end else if (is_day) begin
                n_fwd       = !day_n[16];
                n_days_left = day_abs[15:0];
            end else if (is_mon) begin
                n_status = !tot_ok;
                n_dvd    = total[16:0];
                n_quo    = '0;
                n_rem    = '0;
            end else if (r_req == REQ_EOM) begin
                n_day = cur_len;
            end else begin
                n_month = MON_DEC;
                n_day   = DAY_DEC_END;
            end
        end
        if (i_cmd.day_step) begin
            n_days_left = r_days_left - 16'd1;
            if (r_fwd) begin
                if (r_day < cur_len) begin
                    n_day = r_day + 5'd1;
                end else if (r_month < MON_DEC) begin
                    n_month = r_month + 4'd1;
                    n_day   = 5'd1;
                end else if (r_year < MAX_Y) begin
                    n_year  = r_year + 12'd1;
                    n_month = 4'd1;
                    n_day   = 5'd1;
                end else begin
                    n_days_left = '0;
                end
            end else begin
                if (r_day > 5'd1) begin
                    n_day = r_day - 5'd1;
                end else if (r_month > 4'd1) begin
                    n_month = r_month - 4'd1;
                    n_day   = prev_len;
                end else if (r_year > MIN_Y) begin
                    n_year  = r_year - 12'd1;
                    n_month = MON_DEC;
                    n_day   = DAY_DEC_END;
                end else begin
                    n_days_left = '0;
                end
            end
        end
        if (i_cmd.div_step) begin
            n_quo = quo_full[11:0];
            n_rem = div_rem;
        end
        if (i_cmd.clamp) begin
            n_year  = r_quo;
            n_month = r_rem + 4'd1;
            if (r_day > tgt_len) n_day = tgt_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year      <= '0;
            r_month     <= '0;
            r_day       <= '0;
            r_days_left <= '0;
        end else begin
            r_year      <= n_year;
            r_month     <= n_month;
            r_day       <= n_day;
            r_days_left <= n_days_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd    <= n_fwd;
        r_status <= n_status;
        r_dvd    <= n_dvd;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        if (i_cmd.capture) begin
            r_req <= t_req'(i_req_type);
            r_amt <= i_amount;
            r_ly  <= i_load_year;
            r_lm  <= i_load_month;
            r_ld  <= i_load_day;
        end
    end

    // Result flags and serial day number, registered at the end of a request.
    logic        leap, in_span;
    logic [8:0]  yy;
    logic [16:0] serial;

    always_comb begin
        leap    = (r_year[1:0] == 2'b00);
        in_span = cur_ok && (r_year >= SERIAL_FIRST) && (r_year <= SERIAL_LAST);
        yy      = 9'(r_year - SERIAL_FIRST);
        serial  = 17'(yy) * 17'd365 + 17'((r_year - 12'd1) >> 2) - 17'd474
                  - 17'(r_year > SERIAL_GAP) + 17'(month_start(r_month))
                  + 17'((r_month > MON_FEB) && leap) + 17'(r_day);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_year         <= r_year;
            o_month        <= r_month;
            o_day          <= r_day;
            o_date_valid   <= cur_ok;
            o_leap_year    <= leap;
            o_end_of_month <= (cur_len != 5'd0) && (r_day == cur_len);
            o_end_of_year  <= (r_month == MON_DEC) && (r_day == DAY_DEC_END);
            o_serial_day   <= in_span ? serial : 17'd0;
            o_status       <= r_status;
        end
    end

endmodule

FILE: src/calendar_date_stepper_unit.sv
// ----------------------------------------------------------------------------
// calendar_date_stepper_unit
// Holds one calendar date and serves load, add and end-of-period requests.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Content
//  request   in         i_valid / o_ready   req_type, amount, load date
//  reply     out        o_valid / i_ready   date, flags, serial day, status
//
// A load or end-of-period request goes from decode straight to the reply.
// A day or week move walks the date one day per cycle until its count is
// used up or a year bound is met; the largest week move steps 28672 days.
// In month, quarter and year moves, one reciprocal multiplication splits the
// month count into year and month, and the day is clamped in the next cycle,
// before the reply is registered.
// Reset is synchronous and active low; it clears the date to zero, which is
// not a valid date, so moves are rejected until a good load.
// The reply sits in an output register; a new request item is taken while it
// waits, and that item's reply is held back until the register is free.
module calendar_date_stepper_unit import cdsu_pkg::*; #(
    parameter int MIN_YEAR = DEF_MIN_YEAR,
    parameter int MAX_YEAR = DEF_MAX_YEAR
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic        [2:0]  i_req_type,
    input  logic signed [12:0] i_amount,
    input  logic        [11:0] i_load_year,
    input  logic        [3:0]  i_load_month,
    input  logic        [4:0]  i_load_day,
    output logic               o_valid,
    input  logic               i_ready,
    output logic        [11:0] o_year,
    output logic        [3:0]  o_month,
    output logic        [4:0]  o_day,
    output logic               o_date_valid,
    output logic               o_leap_year,
    output logic               o_end_of_month,
    output logic               o_end_of_year,
    output logic        [16:0] o_serial_day,
    output logic               o_status
);

    t_cmd cmd;
    t_sts sts;

    // The sequencer owns both handshakes and steps the datapath by command.
    cdsu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // The datapath holds the date, the day counter, the divider and the reply.
    cdsu_dpath #(
        .MIN_YEAR (MIN_YEAR),
        .MAX_YEAR (MAX_YEAR)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_req_type     (i_req_type),
        .i_amount       (i_amount),
        .i_load_year    (i_load_year),
        .i_load_month   (i_load_month),
        .i_load_day     (i_load_day),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day          (o_day),
        .o_date_valid   (o_date_valid),
        .o_leap_year    (o_leap_year),
        .o_end_of_month (o_end_of_month),
        .o_end_of_year  (o_end_of_year),
        .o_serial_day   (o_serial_day),
        .o_status       (o_status)
    );

endmodule
